FILE: rtl/core/dads_pkg.sv
// Shared types and constants for the differential arc drive speed core.
// No dependencies; every other file in rtl/core imports this package.
package dads_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_SPEED  = 3'd0;
    localparam logic [2:0] CFG_MIN_SPEED  = 3'd1;
    localparam logic [2:0] CFG_GAIN       = 3'd2;
    localparam logic [2:0] CFG_RATIO      = 3'd3;
    localparam logic [2:0] CFG_PATH_LEN   = 3'd4;
    localparam logic [2:0] CFG_OUTER_LEFT = 3'd5;

    // Ratio of one in Q1.16 marks a straight path.
    localparam logic signed [17:0] RATIO_ONE = 18'sd65536;

    // Quotient bits produced by the divider, one per stage.
    localparam int DIV_STEPS = 16;

    // Per-item flags that travel alongside the arithmetic.
    typedef struct packed {
        logic straight;      // ratio is exactly one
        logic finished;      // arc end reached or zero length
        logic done_straight; // left distance has reached the length
        logic e_full;        // outer distance is zero, fraction is one
    } side_t;

endpackage

FILE: rtl/core/dads_front.sv
// Input stage: magnitudes of length and wheel distances, and the path flags.
// Depends on dads_pkg.
module dads_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic signed [31:0]   left_distance,
    input  logic signed [31:0]   right_distance,
    input  logic signed [31:0]   path_length,
    input  logic signed [17:0]   inner_ratio,
    input  logic                 outer_is_left,
    output logic [31:0]          len_mag,
    output logic [31:0]          rem_init,
    output logic [31:0]          outer_mag,
    output logic [31:0]          inner_mag,
    output dads_pkg::side_t      side
);
    import dads_pkg::*;

    logic [31:0] len_abs;
    logic [31:0] left_abs;
    logic [31:0] right_abs;
    logic [31:0] outer_abs;
    logic [31:0] inner_abs;
    side_t       side_next;

    // Magnitudes in 32 unsigned bits hold the most negative value correctly.
    always_comb
    begin
        len_abs   = path_length[31] ? 32'(-path_length) : 32'(path_length);
        left_abs  = left_distance[31] ? 32'(-left_distance) : 32'(left_distance);
        right_abs = right_distance[31] ? 32'(-right_distance) : 32'(right_distance);
        outer_abs = outer_is_left ? left_abs : right_abs;
        inner_abs = outer_is_left ? right_abs : left_abs;
        side_next.straight      = (inner_ratio == RATIO_ONE);
        side_next.finished      = (outer_abs >= len_abs);
        side_next.done_straight = (left_distance >= path_length);
        side_next.e_full        = (outer_abs == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side <= '0;
        end
        else if (ce)
        begin
            side <= side_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            len_mag   <= len_abs;
            rem_init  <= len_abs - outer_abs;
            outer_mag <= outer_abs;
            inner_mag <= inner_abs;
        end
    end

endmodule

FILE: rtl/core/dads_div.sv
// Pipelined restoring divider for the remaining path fraction, one bit a stage.
// Depends on dads_pkg.
module dads_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic [31:0]                   rem_in,
    input  logic [31:0]                   den_in,
    input  dads_pkg::side_t               side_in,
    output logic [dads_pkg::DIV_STEPS-1:0] quo,
    output dads_pkg::side_t               side_out
);
    import dads_pkg::*;

    logic [31:0]          rem_reg  [0:DIV_STEPS];
    logic [31:0]          den_reg  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg  [0:DIV_STEPS];
    side_t                side_reg [0:DIV_STEPS];

    // Stage zero is the front register itself.
    always_comb
    begin
        rem_reg[0]  = rem_in;
        den_reg[0]  = den_in;
        quo_reg[0]  = '0;
        side_reg[0] = side_in;
    end

    // Each stage doubles the remainder and takes off the divisor where it fits.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [32:0] trial;
        logic        fits;

        always_comb
        begin
            trial = {rem_reg[k], 1'b0};
            fits  = (trial >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k+1] <= '0;
            end
            else if (ce)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k+1] <= fits ? 32'(trial - {1'b0, den_reg[k]}) : trial[31:0];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= {quo_reg[k][DIV_STEPS-2:0], fits};
            end
        end
    end

    assign quo      = quo_reg[DIV_STEPS];
    assign side_out = side_reg[DIV_STEPS];

endmodule

FILE: rtl/core/dads_corr.sv
// Wheel mismatch correction term, computed alongside the divider.
// Depends on dads_pkg; parameter LAT, at least six.
module dads_corr
#(
    parameter int DIST_FRAC_BITS = 16,
    parameter int LAT            = 16
)
(
    input  logic                clk,
    input  logic                ce,
    input  logic [31:0]         outer_mag,
    input  logic [31:0]         inner_mag,
    input  logic signed [17:0]  inner_ratio,
    input  logic [23:0]         mismatch_gain,
    input  logic signed [15:0]  min_speed,
    output logic signed [47:0]  corr
);
    import dads_pkg::*;

    localparam logic signed [60:0] DIFF_HI = 61'sd1 <<< 46;
    localparam logic signed [60:0] DIFF_LO = -(61'sd1 <<< 46);

    logic signed [50:0] p1_reg;
    logic [31:0]        sh_reg;
    logic signed [35:0] m_reg;
    logic signed [60:0] p2_reg;
    logic signed [47:0] d_reg;
    logic signed [63:0] p3_reg;
    logic signed [47:0] c_pipe [0:LAT-6];
    logic signed [60:0] d_wide;

    always_comb
    begin
        d_wide = p2_reg >>> DIST_FRAC_BITS;
    end

    // Ratio-scaled outer distance, mismatch, gain, clamp, then min-speed scale.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg <= $signed({1'b0, outer_mag}) * inner_ratio;
            sh_reg <= inner_mag;
            m_reg  <= 36'(p1_reg >>> 16) - 36'($signed({1'b0, sh_reg}));
            p2_reg <= m_reg * $signed({1'b0, mismatch_gain});
            if (d_wide > DIFF_HI)
            begin
                d_reg <= 48'(DIFF_HI);
            end
            else if (d_wide < DIFF_LO)
            begin
                d_reg <= 48'(DIFF_LO);
            end
            else
            begin
                d_reg <= 48'(d_wide);
            end
            p3_reg    <= d_reg * min_speed;
            c_pipe[0] <= 48'(p3_reg >>> 16);
        end
    end

    // Delay line to line the term up with the divider output.
    for (genvar i = 1; i <= LAT - 6; i++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                c_pipe[i] <= c_pipe[i-1];
            end
        end
    end

    assign corr = c_pipe[LAT-6];

endmodule

FILE: rtl/core/dads_ease.sv
// Smootherstep easing, speed scaling, correction and output selection.
// Depends on dads_pkg; eight register stages, the last one drives the outputs.
module dads_ease
#(
    parameter int SPEED_FRAC_BITS = 14
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic [dads_pkg::DIV_STEPS-1:0]  quo,
    input  dads_pkg::side_t                 side_in,
    input  logic signed [47:0]              corr,
    input  logic signed [15:0]              max_speed,
    input  logic signed [15:0]              min_speed,
    input  logic signed [17:0]              inner_ratio,
    input  logic                            outer_is_left,
    output logic signed [15:0]              left_speed,
    output logic signed [15:0]              right_speed,
    output logic                            speeds_valid,
    output logic                            done_res
);
    import dads_pkg::*;

    localparam logic signed [48:0] SAT_HI = 49'sd1 <<< SPEED_FRAC_BITS;
    localparam logic signed [48:0] SAT_LO = -(49'sd1 <<< SPEED_FRAC_BITS);

    side_t              side_reg [1:7];
    logic signed [47:0] c_reg    [1:7];
    logic [16:0]        e_reg    [1:3];
    logic [16:0]        x2_reg;
    logic [16:0]        x3_reg   [3:5];
    logic [16:0]        x4_reg   [4:5];
    logic [16:0]        x5_reg;
    logic [16:0]        s_reg;
    logic signed [19:0] vlong_reg [6:7];
    logic signed [21:0] vshort_reg;

    logic [16:0]        e_now;
    logic [33:0]        sq;
    logic [33:0]        cube;
    logic [33:0]        quart;
    logic [33:0]        quint;
    logic signed [23:0] s_raw;
    logic signed [34:0] scale_prod;
    logic signed [37:0] ratio_prod;
    logic signed [48:0] so_wide;
    logic signed [48:0] si_wide;
    logic signed [48:0] vmax_wide;
    logic [15:0]        so;
    logic [15:0]        si;
    logic [15:0]        vmax_sat;

    // Powers of the fraction, one multiplier per stage.
    always_comb
    begin
        e_now  = side_in.e_full ? 17'h10000 : {1'b0, quo};
        sq     = e_now * e_now;
        cube   = x2_reg * e_reg[1];
        quart  = x3_reg[3] * e_reg[2];
        quint  = x4_reg[4] * e_reg[3];
        s_raw  = 24'(6 * x5_reg) - 24'(15 * x4_reg[5]) + 24'(10 * x3_reg[5]);
        scale_prod = $signed({1'b0, s_reg}) * (17'(max_speed) - 17'(min_speed));
        ratio_prod = inner_ratio * vlong_reg[6];
    end

    // Saturated outer and inner speeds, and the straight-path speed.
    always_comb
    begin
        so_wide   = 49'(vlong_reg[7]) - 49'(c_reg[7]);
        si_wide   = 49'(vshort_reg) + 49'(c_reg[7]);
        vmax_wide = 49'(max_speed);
        if (so_wide > SAT_HI)
        begin
            so = SAT_HI[15:0];
        end
        else if (so_wide < SAT_LO)
        begin
            so = SAT_LO[15:0];
        end
        else
        begin
            so = so_wide[15:0];
        end
        if (si_wide > SAT_HI)
        begin
            si = SAT_HI[15:0];
        end
        else if (si_wide < SAT_LO)
        begin
            si = SAT_LO[15:0];
        end
        else
        begin
            si = si_wide[15:0];
        end
        if (vmax_wide > SAT_HI)
        begin
            vmax_sat = SAT_HI[15:0];
        end
        else if (vmax_wide < SAT_LO)
        begin
            vmax_sat = SAT_LO[15:0];
        end
        else
        begin
            vmax_sat = vmax_wide[15:0];
        end
    end

    // Flags and correction term travel with the item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 7; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (ce)
        begin
            side_reg[1] <= side_in;
            for (int i = 2; i <= 7; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c_reg[1] <= corr;
            for (int i = 2; i <= 7; i++)
            begin
                c_reg[i] <= c_reg[i-1];
            end
            e_reg[1]  <= e_now;
            e_reg[2]  <= e_reg[1];
            e_reg[3]  <= e_reg[2];
            x2_reg    <= sq[32:16];
            x3_reg[3] <= cube[32:16];
            x3_reg[4] <= x3_reg[3];
            x3_reg[5] <= x3_reg[4];
            x4_reg[4] <= quart[32:16];
            x4_reg[5] <= x4_reg[4];
            x5_reg    <= quint[32:16];
            // Smootherstep clamped to the unit interval.
            if (s_raw < 24'sd0)
            begin
                s_reg <= 17'd0;
            end
            else if (s_raw > 24'sd65536)
            begin
                s_reg <= 17'h10000;
            end
            else
            begin
                s_reg <= s_raw[16:0];
            end
            vlong_reg[6] <= 20'(min_speed) + 20'(scale_prod >>> 16);
            vlong_reg[7] <= vlong_reg[6];
            vshort_reg   <= 22'(ratio_prod >>> 16);
        end
    end

    // Output register: straight path, arc end, or corrected arc speeds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_speed   <= '0;
            right_speed  <= '0;
            speeds_valid <= 1'b0;
            done_res     <= 1'b0;
        end
        else if (ce)
        begin
            if (side_reg[7].straight)
            begin
                left_speed   <= vmax_sat;
                right_speed  <= vmax_sat;
                speeds_valid <= 1'b1;
                done_res     <= side_reg[7].done_straight;
            end
            else if (side_reg[7].finished)
            begin
                left_speed   <= '0;
                right_speed  <= '0;
                speeds_valid <= 1'b0;
                done_res     <= 1'b1;
            end
            else
            begin
                left_speed   <= outer_is_left ? so : si;
                right_speed  <= outer_is_left ? si : so;
                speeds_valid <= 1'b1;
                done_res     <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/differential_arc_drive_speed_core.sv
// Top level of the differential arc drive speed core: registers and pipeline.
// Depends on dads_pkg, dads_front, dads_div, dads_corr and dads_ease.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | left_distance, right_distance
//  output   | out_valid / out_stall| left_speed, right_speed, speeds_valid, done_res
//  config   | cfg_we               | cfg_index, cfg_data
//
// One item enters per cycle while in_stall is low; each item passes 25 register
// stages (input stage, 16 one-bit divider stages and 8 easing stages), and the
// last easing stage offers its result.
// Reset clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipeline; in_stall follows out_stall while
// a result is waiting.
module differential_arc_drive_speed_core
#(
    parameter int DIST_FRAC_BITS  = 16,
    parameter int SPEED_FRAC_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] left_distance,
    input  logic signed [31:0] right_distance,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed,
    output logic               speeds_valid,
    output logic               done_res,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import dads_pkg::*;

    localparam int LAT = DIV_STEPS + 9;

    logic signed [15:0] max_speed_reg;
    logic signed [15:0] min_speed_reg;
    logic [23:0]        gain_reg;
    logic signed [17:0] ratio_reg;
    logic signed [31:0] path_len_reg;
    logic               outer_left_reg;
    logic [LAT-1:0]     vld_reg;
    logic               ce;

    logic [31:0]          len_mag;
    logic [31:0]          rem_init;
    logic [31:0]          outer_mag;
    logic [31:0]          inner_mag;
    side_t                front_side;
    side_t                div_side;
    logic [DIV_STEPS-1:0] quo;
    logic signed [47:0]   corr;

    // The whole pipeline advances unless a finished result is held.
    assign ce        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = vld_reg[LAT-1] && out_stall;
    assign out_valid = vld_reg[LAT-1];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg  <= 16'sd16384;
            min_speed_reg  <= 16'sd0;
            gain_reg       <= 24'd0;
            ratio_reg      <= RATIO_ONE;
            path_len_reg   <= 32'sd0;
            outer_left_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_SPEED:  max_speed_reg  <= cfg_data[15:0];
                CFG_MIN_SPEED:  min_speed_reg  <= cfg_data[15:0];
                CFG_GAIN:       gain_reg       <= cfg_data[23:0];
                CFG_RATIO:      ratio_reg      <= cfg_data[17:0];
                CFG_PATH_LEN:   path_len_reg   <= cfg_data;
                CFG_OUTER_LEFT: outer_left_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    dads_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ce             (ce),
        .left_distance  (left_distance),
        .right_distance (right_distance),
        .path_length    (path_len_reg),
        .inner_ratio    (ratio_reg),
        .outer_is_left  (outer_left_reg),
        .len_mag        (len_mag),
        .rem_init       (rem_init),
        .outer_mag      (outer_mag),
        .inner_mag      (inner_mag),
        .side           (front_side)
    );

    dads_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .rem_in   (rem_init),
        .den_in   (len_mag),
        .side_in  (front_side),
        .quo      (quo),
        .side_out (div_side)
    );

    dads_corr
    #(
        .DIST_FRAC_BITS (DIST_FRAC_BITS),
        .LAT            (DIV_STEPS)
    )
    u_corr
    (
        .clk           (clk),
        .ce            (ce),
        .outer_mag     (outer_mag),
        .inner_mag     (inner_mag),
        .inner_ratio   (ratio_reg),
        .mismatch_gain (gain_reg),
        .min_speed     (min_speed_reg),
        .corr          (corr)
    );

    dads_ease
    #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    )
    u_ease
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ce            (ce),
        .quo           (quo),
        .side_in       (div_side),
        .corr          (corr),
        .max_speed     (max_speed_reg),
        .min_speed     (min_speed_reg),
        .inner_ratio   (ratio_reg),
        .outer_is_left (outer_left_reg),
        .left_speed    (left_speed),
        .right_speed   (right_speed),
        .speeds_valid  (speeds_valid),
        .done_res      (done_res)
    );

    // The input is held back only while a result waits.
    a_stall_src : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    // A result without new speeds always marks the path end, with zero speeds.
    a_end_marks : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !speeds_valid |-> done_res && left_speed == 16'sd0
            && right_speed == 16'sd0)
        else $error("end-of-path result malformed");

    // A held pipeline keeps its valid bits.
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // A result not taken is still there in the next cycle.
    a_keep : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_speed))
        else $error("waiting result lost");

endmodule
